[src/tccw_pkg.sv]
// tccw_pkg: shared constants, codes and control structs for the text console cell writer
// used by tccw_ctrl, tccw_dp, text_console_cell_writer and the testbench; depends on nothing

package tccw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // field widths
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int NIB_W      = 4;
  localparam int CELL_W     = CHAR_W + COLOR_W;
  localparam int ROW_FLD_W  = 5;
  localparam int COL_FLD_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  // colors
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
  localparam logic [NIB_W-1:0]   FG_RESET    = 4'd7;
  localparam logic [NIB_W-1:0]   BG_RESET    = 4'd0;

  // request types
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic addr_ld;
    logic mem_op;
    logic load_out;
    logic clear_wr;
    logic blank_wr;
  } tccw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic blank_last;
    logic scroll;
    logic out_free;
  } tccw_status_t;

endpackage

[src/tccw_ram.sv]
// tccw_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies

module tccw_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 2000,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/tccw_ctrl.sv]
// tccw_ctrl: controller state machine sequencing clear, item steps and row blanking
// depends on tccw_pkg for the command and status structs

module tccw_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tccw_pkg::tccw_status_t st,
  output tccw_pkg::tccw_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_MEM   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_BLANK = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr_ld = 1'b1;
        state_nxt   = S_MEM;
      end
      S_MEM: begin
        cmd.mem_op = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = st.scroll ? S_BLANK : S_IDLE;
        end
      end
      S_BLANK: begin
        cmd.blank_wr = 1'b1;
        if (st.blank_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/tccw_dp.sv]
// tccw_dp: datapath with cursor, scroll offset, color registers, address path and screen ram
// depends on tccw_pkg and tccw_ram

module tccw_dp #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tccw_pkg::tccw_cmd_t                cmd,
  output tccw_pkg::tccw_status_t             st,
  input  logic                               cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_req_type,
  input  logic [tccw_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [tccw_pkg::ROW_FLD_W-1:0]     in_read_row,
  input  logic [tccw_pkg::COL_FLD_W-1:0]     in_read_col,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tccw_pkg::CHAR_W-1:0]        out_cell_char,
  output logic [tccw_pkg::COLOR_W-1:0]       out_cell_color,
  output logic [tccw_pkg::ROW_FLD_W-1:0]     out_cursor_row,
  output logic [tccw_pkg::COL_FLD_W-1:0]     out_cursor_col
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int RS_W   = ROW_W + 1;
  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = tccw_pkg::CELL_W;
  localparam int ORW    = tccw_pkg::ROW_FLD_W;
  localparam int OCW    = tccw_pkg::COL_FLD_W;

  // color registers
  logic [tccw_pkg::NIB_W-1:0] fg_r, bg_r;

  // cursor and scroll state
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  top_r;
  logic [ADDR_W-1:0] top_base_r;

  // transaction registers
  logic                        req_r;
  logic [tccw_pkg::CHAR_W-1:0] ch_r;
  logic [COL_W-1:0]            col_r;
  logic [ROW_W-1:0]            prow_r;
  logic                        rd_ok_r;
  logic [ADDR_W-1:0]           addr_r;
  logic                        scroll_r;
  logic [CW-1:0]               blank_cell_r;

  // sweep state for clearing and blanking
  logic [ADDR_W-1:0] sweep_addr_r;
  logic [COL_W-1:0]  sweep_cnt_r;

  // output register
  logic                         out_valid_r;
  logic [tccw_pkg::CHAR_W-1:0]  out_char_r;
  logic [tccw_pkg::COLOR_W-1:0] out_color_r;
  logic [ORW-1:0]               out_row_r;
  logic [OCW-1:0]               out_col_r;

  // combinational
  logic [ROW_W-1:0]  vis_sel;
  logic [RS_W-1:0]   row_sum;
  logic [ROW_W-1:0]  prow;
  logic              rd_ok;
  logic              last_col, last_row;
  logic              row_adv, cell_wr, scroll;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CW-1:0]     ram_wdata, ram_rdata;
  logic [CW-1:0]     reset_cell;

  assign reset_cell = {tccw_pkg::RESET_COLOR, tccw_pkg::CH_SPACE};

  // physical row of the visible row, top offset added modulo rows
  always_comb begin
    vis_sel = (in_req_type == tccw_pkg::REQ_READ) ? ROW_W'(in_read_row) : cur_row_r;
    row_sum = RS_W'(top_r) + RS_W'(vis_sel);
    prow    = (row_sum >= RS_W'(ROWS)) ? ROW_W'(row_sum - RS_W'(ROWS)) : ROW_W'(row_sum);
    rd_ok   = (int'(in_read_row) < ROWS) && (int'(in_read_col) < COLUMNS);
  end

  // cursor step for a put
  always_comb begin
    last_col    = (cur_col_r == COL_W'(COLUMNS - 1));
    last_row    = (cur_row_r == ROW_W'(ROWS - 1));
    cell_wr     = 1'b0;
    row_adv     = 1'b0;
    cur_col_nxt = cur_col_r;
    priority if (ch_r == tccw_pkg::CH_NEWLINE) begin
      cur_col_nxt = '0;
      row_adv     = 1'b1;
    end else if (ch_r == tccw_pkg::CH_RETURN) begin
      cur_col_nxt = '0;
    end else begin
      cell_wr     = 1'b1;
      cur_col_nxt = last_col ? '0 : cur_col_r + 1'b1;
      row_adv     = last_col;
    end
    scroll      = row_adv && last_row;
    cur_row_nxt = (row_adv && !last_row) ? cur_row_r + 1'b1 : cur_row_r;
  end

  function automatic logic last_row_top();
    return top_r == ROW_W'(ROWS - 1);
  endfunction

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r         <= tccw_pkg::FG_RESET;
      bg_r         <= tccw_pkg::BG_RESET;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      top_r        <= '0;
      top_base_r   <= '0;
      sweep_addr_r <= '0;
      sweep_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          tccw_pkg::CFG_FG: fg_r <= cfg_wdata;
          tccw_pkg::CFG_BG: bg_r <= cfg_wdata;
          default: ;
        endcase
      end
      // cursor update and scroll start
      if (cmd.mem_op && req_r == tccw_pkg::REQ_PUT) begin
        cur_row_r <= cur_row_nxt;
        cur_col_r <= cur_col_nxt;
        if (scroll) begin
          top_r        <= last_row_top() ? '0 : top_r + 1'b1;
          top_base_r   <= last_row_top() ? '0 : top_base_r + ADDR_W'(COLUMNS);
          sweep_addr_r <= top_base_r;
          sweep_cnt_r  <= '0;
        end
      end
      // sweep counters
      if (cmd.clear_wr || cmd.blank_wr) begin
        sweep_addr_r <= sweep_addr_r + 1'b1;
        sweep_cnt_r  <= sweep_cnt_r + 1'b1;
      end
      // output valid
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r   <= in_req_type;
      ch_r    <= in_char_code;
      col_r   <= (in_req_type == tccw_pkg::REQ_READ) ? COL_W'(in_read_col) : cur_col_r;
      prow_r  <= prow;
      rd_ok_r <= (in_req_type == tccw_pkg::REQ_READ) && rd_ok;
    end
    if (cmd.addr_ld) begin
      addr_r <= ADDR_W'(prow_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
    end
    if (cmd.mem_op) begin
      scroll_r     <= (req_r == tccw_pkg::REQ_PUT) && scroll;
      blank_cell_r <= {bg_r, fg_r, tccw_pkg::CH_SPACE};
    end
    if (cmd.load_out) begin
      out_char_r  <= rd_ok_r ? ram_rdata[tccw_pkg::CHAR_W-1:0] : '0;
      out_color_r <= rd_ok_r ? ram_rdata[CW-1:tccw_pkg::CHAR_W] : '0;
      out_row_r   <= ORW'(cur_row_r);
      out_col_r   <= OCW'(cur_col_r);
    end
  end

  // ram port selection
  always_comb begin
    ram_we    = cmd.clear_wr || cmd.blank_wr ||
                (cmd.mem_op && req_r == tccw_pkg::REQ_PUT && cell_wr);
    ram_re    = cmd.mem_op && req_r == tccw_pkg::REQ_READ;
    ram_waddr = cmd.mem_op ? addr_r : sweep_addr_r;
    priority if (cmd.clear_wr) begin
      ram_wdata = reset_cell;
    end else if (cmd.blank_wr) begin
      ram_wdata = blank_cell_r;
    end else begin
      ram_wdata = {bg_r, fg_r, ch_r};
    end
  end

  tccw_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // status to controller
  assign st.clear_last = (sweep_addr_r == ADDR_W'(DEPTH - 1));
  assign st.blank_last = (sweep_cnt_r == COL_W'(COLUMNS - 1));
  assign st.scroll     = scroll_r;
  assign st.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_color = out_color_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

endmodule

[src/text_console_cell_writer.sv]
// text_console_cell_writer: top level of the text console, controller plus datapath
// depends on tccw_pkg, tccw_ctrl and tccw_dp

// The console holds ROWS x COLUMNS cells (character byte low, color byte high) in one
// block ram. After reset the block runs a clearing pass that writes a space in color
// 0x07 to every cell, with in_ready low; configuration writes are taken during it. An
// item then passes through accept and row lookup, cell address, ram access and result
// load in turn, and no new item is accepted until its result has been loaded. A put
// that moves the cursor past the last row scrolls by rotating the top-row offset and
// then blanks the old top row one cell per cycle, with no item accepted until the
// blanking ends; the blank color is the one in force at the scroll. Each result waits
// in an output register until taken.

module text_console_cell_writer #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [tccw_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [tccw_pkg::ROW_FLD_W-1:0]     in_read_row,
  input  logic [tccw_pkg::COL_FLD_W-1:0]     in_read_col,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tccw_pkg::CHAR_W-1:0]        out_cell_char,
  output logic [tccw_pkg::COLOR_W-1:0]       out_cell_color,
  output logic [tccw_pkg::ROW_FLD_W-1:0]     out_cursor_row,
  output logic [tccw_pkg::COL_FLD_W-1:0]     out_cursor_col
);

  tccw_pkg::tccw_cmd_t    cmd;
  tccw_pkg::tccw_status_t st;

  // sequencer
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // cursor, colors, address path and screen memory
  tccw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_char  (out_cell_char),
    .out_cell_color (out_cell_color),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col)
  );

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // a loaded result is offered on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  // no item is taken while the screen is being cleared or blanked
  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_wr || cmd.blank_wr |-> !in_ready)
    else $error("input ready during a sweep");

  // reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_col) < COLUMNS) && (int'(out_cursor_row) < ROWS))
    else $error("cursor out of range");

endmodule

[sim/testbench.sv]
// testbench: self-checking regression for the text console cell writer
// drives put and read transactions plus color register writes; depends on tccw_pkg
// and text_console_cell_writer, checks each result against the console model below or a scripted value
`timescale 1ns / 1ps

module testbench;
  import tccw_pkg::*;

  localparam int COLUMNS    = COLUMNS_DEF;
  localparam int ROWS       = ROWS_DEF;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 200;
  localparam int LONG_HOLD  = 120;
  localparam int SETTLE_CYC = COLUMNS + 20;

  typedef struct packed {
    logic                 req;
    logic [CHAR_W-1:0]    ch;
    logic [ROW_FLD_W-1:0] row;
    logic [COL_FLD_W-1:0] col;
  } console_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]    chr;
    logic [COLOR_W-1:0]   color;
    logic [ROW_FLD_W-1:0] crow;
    logic [COL_FLD_W-1:0] ccol;
  } console_resp_t;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [NIB_W-1:0]     reg_val;
    int                   reps;
    console_req_t         rq;
    bit                   typed;
    console_resp_t        want;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [CHAR_W-1:0]     in_char_code;
  logic [ROW_FLD_W-1:0]  in_read_row;
  logic [COL_FLD_W-1:0]  in_read_col;
  logic                  out_valid;
  logic                  out_ready;
  logic [CHAR_W-1:0]     out_cell_char;
  logic [COLOR_W-1:0]    out_cell_color;
  logic [ROW_FLD_W-1:0]  out_cursor_row;
  logic [COL_FLD_W-1:0]  out_cursor_col;

  // console model state
  logic [CELL_W-1:0] screen_mem [ROWS*COLUMNS];
  int unsigned       model_row;
  int unsigned       model_col;
  int unsigned       model_top;
  logic [NIB_W-1:0]  model_fg;
  logic [NIB_W-1:0]  model_bg;

  console_resp_t pending_resp_q[$];
  script_row_t   script[$];

  int  err_count;
  int  n_put;
  int  n_read;
  int  n_scroll;
  int  n_wrap;
  int  n_checked;
  bit  quiet;
  bit  hold_req;

  text_console_cell_writer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_char  (out_cell_char),
    .out_cell_color (out_cell_color),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // apply one transaction to the console model and return its result
  function automatic console_resp_t console_step(console_req_t rq);
    console_resp_t    r;
    logic [CELL_W-1:0] cell_word;
    logic [COLOR_W-1:0] color;
    int unsigned       x;
    r     = '0;
    color = {model_bg, model_fg};
    if (rq.req == REQ_PUT) begin
      n_put++;
      if (rq.ch == CH_NEWLINE) begin
        model_col = 0;
        model_row++;
      end else if (rq.ch == CH_RETURN) begin
        model_col = 0;
      end else begin
        screen_mem[((model_top + model_row) % ROWS) * COLUMNS + model_col] = {color, rq.ch};
        model_col++;
        if (model_col >= COLUMNS) begin
          model_col = 0;
          model_row++;
          n_wrap++;
        end
      end
      // scroll: rotate the top row and blank the row that falls off
      if (model_row >= ROWS) begin
        for (x = 0; x < COLUMNS; x++)
          screen_mem[model_top * COLUMNS + x] = {color, CH_SPACE};
        model_top = (model_top + 1) % ROWS;
        model_row = ROWS - 1;
        n_scroll++;
      end
    end else begin
      n_read++;
      if (rq.row < ROWS && rq.col < COLUMNS) begin
        cell_word = screen_mem[((model_top + rq.row) % ROWS) * COLUMNS + rq.col];
        r.chr     = cell_word[CHAR_W-1:0];
        r.color   = cell_word[CELL_W-1:CHAR_W];
      end
    end
    r.crow = model_row[ROW_FLD_W-1:0];
    r.ccol = model_col[COL_FLD_W-1:0];
    return r;
  endfunction

  // random transaction; text mode favors long runs of characters so lines wrap
  function automatic console_req_t random_req(bit text_mode);
    console_req_t rq;
    int           pick;
    rq.req = REQ_PUT;
    rq.ch  = CHAR_W'($urandom_range(0, 255));
    rq.row = ROW_FLD_W'($urandom);
    rq.col = COL_FLD_W'($urandom);
    pick   = $urandom_range(0, 99);
    if (text_mode) begin
      if (pick < 2)
        rq.ch = CH_NEWLINE;
      else if (pick < 3)
        rq.ch = CH_RETURN;
      else if (pick >= 85)
        rq.req = REQ_READ;
    end else begin
      if (pick < 12)
        rq.ch = CH_NEWLINE;
      else if (pick < 18)
        rq.ch = CH_RETURN;
      else if (pick >= 60)
        rq.req = REQ_READ;
    end
    // mostly in-range reads, the rest use the full field range
    if (rq.req == REQ_READ && $urandom_range(0, 9) < 8) begin
      rq.row = ROW_FLD_W'($urandom_range(0, ROWS - 1));
      rq.col = COL_FLD_W'($urandom_range(0, COLUMNS - 1));
    end
    return rq;
  endfunction

  task automatic report(input string fld, input int unsigned want, input int unsigned got);
    err_count++;
    $display("%0t ns: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, fld, want, got);
  endtask

  // result monitor
  always @(posedge clk) begin
    console_resp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_resp_q.size() == 0) begin
        err_count++;
        $display("%0t ns: result with nothing expected, char 0x%0h color 0x%0h", $time,
                 out_cell_char, out_cell_color);
      end else begin
        want = pending_resp_q.pop_front();
        n_checked++;
        if (out_cell_char !== want.chr) report("cell_char", want.chr, out_cell_char);
        if (out_cell_color !== want.color) report("cell_color", want.color, out_cell_color);
        if (out_cursor_row !== want.crow) report("cursor_row", want.crow, out_cursor_row);
        if (out_cursor_col !== want.ccol) report("cursor_col", want.ccol, out_cursor_col);
      end
    end
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        hold_req  = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // offer one transaction, record its expected result, then maybe idle
  task automatic send_req(input console_req_t rq, input bit typed, input console_resp_t want);
    console_resp_t pred;
    int            gap;
    @(negedge clk);
    in_valid     = 1'b1;
    in_req_type  = rq.req;
    in_char_code = rq.ch;
    in_read_row  = rq.row;
    in_read_col  = rq.col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = console_step(rq);
    pending_resp_q.push_back(typed ? want : pred);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering, wait for every result, then let a scroll blank finish
  task automatic settle_console();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_color_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NIB_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_FG)
      model_fg = val;
    else
      model_bg = val;
  endtask

  task automatic add_put(input logic [CHAR_W-1:0] ch, input int reps, input bit typed,
                         input int crow, input int ccol);
    script_row_t s;
    s         = '{default: '0};
    s.reps    = reps;
    s.rq.req  = REQ_PUT;
    s.rq.ch   = ch;
    s.rq.row  = ROW_FLD_W'($urandom);
    s.rq.col  = COL_FLD_W'($urandom);
    s.typed   = typed;
    s.want    = '{chr: '0, color: '0, crow: ROW_FLD_W'(crow), ccol: COL_FLD_W'(ccol)};
    script.push_back(s);
  endtask

  task automatic add_read(input int row, input int col, input logic [CHAR_W-1:0] chr,
                          input logic [COLOR_W-1:0] color, input int crow, input int ccol);
    script_row_t s;
    s        = '{default: '0};
    s.reps   = 1;
    s.rq.req = REQ_READ;
    s.rq.ch  = CHAR_W'($urandom);
    s.rq.row = ROW_FLD_W'(row);
    s.rq.col = COL_FLD_W'(col);
    s.typed  = 1'b1;
    s.want   = '{chr: chr, color: color, crow: ROW_FLD_W'(crow), ccol: COL_FLD_W'(ccol)};
    script.push_back(s);
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NIB_W-1:0] val);
    script_row_t s;
    s         = '{default: '0};
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    script.push_back(s);
  endtask

  // timeout
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // main sequence
  initial begin
    script_row_t   s;
    console_req_t  rq;
    console_resp_t none;
    int            ph;
    int            i;
    int            k;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_FG;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_req_type  = REQ_PUT;
    in_char_code = '0;
    in_read_row  = '0;
    in_read_col  = '0;
    err_count    = 0;
    n_put        = 0;
    n_read       = 0;
    n_scroll     = 0;
    n_wrap       = 0;
    n_checked    = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    none         = '0;
    model_row    = 0;
    model_col    = 0;
    model_top    = 0;
    model_fg     = FG_RESET;
    model_bg     = BG_RESET;
    for (i = 0; i < ROWS * COLUMNS; i++)
      screen_mem[i] = {RESET_COLOR, CH_SPACE};

    // directed script: reset screen, out-of-range reads, controls, scroll color
    add_read(0, 0, CH_SPACE, RESET_COLOR, 0, 0);
    add_read(ROWS - 1, COLUMNS - 1, CH_SPACE, RESET_COLOR, 0, 0);
    add_read(ROWS, 0, 8'h00, 8'h00, 0, 0);
    add_read(0, COLUMNS, 8'h00, 8'h00, 0, 0);
    add_read(31, 127, 8'h00, 8'h00, 0, 0);
    add_put(8'hFF, 1, 1'b1, 0, 1);
    add_put(8'h00, 1, 1'b1, 0, 2);
    add_put(CH_RETURN, 1, 1'b1, 0, 0);
    add_reg(CFG_FG, 4'h0);
    add_reg(CFG_BG, 4'hF);
    add_put(8'h41, 1, 1'b1, 0, 1);
    add_read(0, 0, 8'h41, 8'hF0, 0, 1);
    add_read(0, 1, 8'h00, RESET_COLOR, 0, 1);
    // new color just before the scroll: blanked row must take it
    add_reg(CFG_FG, 4'h2);
    add_reg(CFG_BG, 4'h9);
    add_put(CH_NEWLINE, ROWS, 1'b0, 0, 0);
    add_read(ROWS - 1, 0, CH_SPACE, 8'h92, ROWS - 1, 0);
    add_read(ROWS - 1, COLUMNS - 1, CH_SPACE, 8'h92, ROWS - 1, 0);
    add_read(0, 0, CH_SPACE, RESET_COLOR, ROWS - 1, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[j]) begin
      s = script[j];
      if (s.is_reg) begin
        settle_console();
        write_color_reg(s.reg_idx, s.reg_val);
      end else begin
        for (k = 0; k < s.reps; k++)
          send_req(s.rq, s.typed, s.want);
      end
    end

    // random phases, each with its own color setting
    for (ph = 0; ph < PHASES; ph++) begin
      settle_console();
      if (ph == 0) begin
        write_color_reg(CFG_FG, 4'hF);
        write_color_reg(CFG_BG, 4'hF);
      end else if (ph == 1) begin
        write_color_reg(CFG_FG, 4'h0);
        write_color_reg(CFG_BG, 4'h0);
      end else begin
        write_color_reg(CFG_FG, NIB_W'($urandom));
        write_color_reg(CFG_BG, NIB_W'($urandom));
      end
      quiet = (ph == 5 || ph == PHASES - 1);
      for (i = 0; i < PHASE_LEN; i++) begin
        // long result hold-off while items keep coming
        if (ph == 2 && i == 50)
          hold_req = 1'b1;
        // pause mid-phase until every result is back
        if (ph == 3 && i == PHASE_LEN / 2)
          settle_console();
        rq = random_req(ph[0]);
        send_req(rq, 1'b0, none);
      end
    end

    settle_console();
    if (pending_resp_q.size() != 0) begin
      err_count += pending_resp_q.size();
      $display("%0t ns: %0d results never arrived", $time, pending_resp_q.size());
    end
    $display("covered %0d puts and %0d reads, %0d line wraps, %0d scrolls, %0d results checked",
             n_put, n_read, n_wrap, n_scroll, n_checked);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/tccw_pkg.sv
src/tccw_ram.sv
src/tccw_ctrl.sv
src/tccw_dp.sv
src/text_console_cell_writer.sv
sim/testbench.sv
